// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the keyed-removal queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks a property that always holds, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/fwkr_pkg.sv -----
// Package of the keyed-removal queue: sizes, codes and item types.
`default_nettype none
package fwkr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        key_index;
        logic [31:0]        version;
        logic signed [31:0] value;
        logic [31:0]        dest_addr;
        logic [15:0]        dest_port;
        logic [31:0]        sent_seconds;
        logic [19:0]        sent_microseconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [31:0]        out_key_index;
        logic [31:0]        out_version;
        logic signed [31:0] out_value;
        logic [31:0]        out_dest_addr;
        logic [15:0]        out_dest_port;
        logic [31:0]        out_sent_seconds;
        logic [19:0]        out_sent_microseconds;
        logic [4:0]         occupancy;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        key_index;
        logic [31:0]        version;
        logic signed [31:0] value;
        logic [31:0]        dest_addr;
        logic [15:0]        dest_port;
        logic [31:0]        sent_seconds;
        logic [19:0]        sent_microseconds;
    } entry_t;

    // Per-cell control from the queue controller.
    typedef struct packed {
        logic occupied;
        logic load;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/fwkr_cell.sv -----
// One queue cell: holds an entry, compares it against a remove key and shifts.
`default_nettype none
module fwkr_cell (
    input  wire logic                clk,
    input  wire fwkr_pkg::cell_ctrl_t ctrl,
    input  wire fwkr_pkg::entry_t    new_entry,
    input  wire fwkr_pkg::entry_t    next_entry,
    input  wire logic [31:0]         search_key,
    input  wire logic [31:0]         search_version,
    input  wire logic                hit_in,
    output fwkr_pkg::entry_t         entry,
    output logic                     hit_out
);

    fwkr_pkg::entry_t entry_reg;
    fwkr_pkg::entry_t entry_next;
    logic             match;

    assign match = ctrl.occupied && (entry_reg.key_index == search_key)
                   && (entry_reg.version <= search_version);

    // Once a match sits at or ahead of this cell, this cell takes its
    // neighbor's entry, which closes the gap left by the removed one.
    assign hit_out = hit_in | match;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.pop || (ctrl.remove && hit_out))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ----- hdl/fifo_with_keyed_removal.sv -----
// Top level of the ordered queue with keyed removal, built as a row of cells.
//
//  Channel   Signals                     Handshake
//  --------  --------------------------  ----------------------------------
//  command   start, busy, request        taken when start is high, busy low
//  result    done, result                valid for one cycle while done high
//
// All cells compare and shift in the cycle in which an item is taken, and the
// registered result appears on the cycle after the item is taken.
// busy stays low, so a new item may be given in every cycle.
// Reset empties the queue; the entry payload is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module fifo_with_keyed_removal (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire fwkr_pkg::in_item_t request,
    output logic                    done,
    output fwkr_pkg::out_item_t     result
);

    localparam int D = fwkr_pkg::QUEUE_DEPTH;

    logic [fwkr_pkg::CNT_W-1:0] count_reg;
    logic [fwkr_pkg::CNT_W-1:0] count_next;
    logic                       done_reg;
    fwkr_pkg::out_item_t        result_reg;
    fwkr_pkg::out_item_t        result_next;

    fwkr_pkg::entry_t     entries [D];
    fwkr_pkg::cell_ctrl_t ctrl    [D];
    logic [D:0]           hit;
    fwkr_pkg::entry_t     new_entry;

    logic accept;
    logic is_push;
    logic is_pop;
    logic is_peek;
    logic is_remove;
    logic empty;
    logic full;
    logic found;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_push   = accept && (request.operation == fwkr_pkg::OP_PUSH);
    assign is_pop    = accept && (request.operation == fwkr_pkg::OP_POP);
    assign is_peek   = accept && (request.operation == fwkr_pkg::OP_PEEK);
    assign is_remove = accept && (request.operation == fwkr_pkg::OP_REMOVE);

    assign empty = (count_reg == '0);
    assign full  = (count_reg == fwkr_pkg::CNT_W'(D));

    assign new_entry.key_index         = request.key_index;
    assign new_entry.version           = request.version;
    assign new_entry.value             = request.value;
    assign new_entry.dest_addr         = request.dest_addr;
    assign new_entry.dest_port         = request.dest_port;
    assign new_entry.sent_seconds      = request.sent_seconds;
    assign new_entry.sent_microseconds = request.sent_microseconds;

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        fwkr_pkg::entry_t nbr;

        if (i == D - 1)
        begin : g_last
            assign nbr = entries[i];
        end
        else
        begin : g_mid
            assign nbr = entries[i+1];
        end

        assign ctrl[i].occupied = (fwkr_pkg::CNT_W'(i) < count_reg);
        assign ctrl[i].load     = is_push && !full && (fwkr_pkg::CNT_W'(i) == count_reg);
        assign ctrl[i].pop      = is_pop && !empty;
        assign ctrl[i].remove   = is_remove;

        fwkr_cell u_cell (
            .clk            (clk),
            .ctrl           (ctrl[i]),
            .new_entry      (new_entry),
            .next_entry     (nbr),
            .search_key     (request.key_index),
            .search_version (request.version),
            .hit_in         (hit[i]),
            .entry          (entries[i]),
            .hit_out        (hit[i+1])
        );
    end

    assign found = is_remove && hit[D];

    always_comb
    begin
        count_next = count_reg;
        if (is_push && !full)
        begin
            count_next = count_reg + 1'b1;
        end
        else if ((is_pop && !empty) || found)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        result_next        = '0;
        result_next.found  = found;
        if (is_push && full)
        begin
            result_next.status = fwkr_pkg::ST_FULL;
        end
        else if ((is_pop || is_peek) && empty)
        begin
            result_next.status = fwkr_pkg::ST_EMPTY;
        end
        else if (is_pop || is_peek)
        begin
            result_next.out_key_index         = entries[0].key_index;
            result_next.out_version           = entries[0].version;
            result_next.out_value             = entries[0].value;
            result_next.out_dest_addr         = entries[0].dest_addr;
            result_next.out_dest_port         = entries[0].dest_port;
            result_next.out_sent_seconds      = entries[0].sent_seconds;
            result_next.out_sent_microseconds = entries[0].sent_microseconds;
        end
        result_next.occupancy = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_count_bound, count_reg <= fwkr_pkg::CNT_W'(D), "entry count above depth")
    `ASSERT_CLK(a_done_follows, accept |=> done, "accepted item gave no result")
    `ASSERT_CLK(a_found_remove, done && result.found |-> $past(request.operation) == fwkr_pkg::OP_REMOVE, "found set outside remove")
    `ASSERT_CLK(a_push_grows, is_push && !full |=> count_reg == $past(count_reg) + 1'b1, "push did not grow queue")

endmodule
`default_nettype wire

// ----- tb/sv/tb_fifo_with_keyed_removal.sv -----
// Self-checking testbench of the keyed-removal queue with a built-in queue predictor.
`default_nettype none
module tb_fifo_with_keyed_removal;
    timeunit 1ns;
    timeprecision 1ps;

    import fwkr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1025;
    localparam int unsigned CYCLE_LIMIT = 60000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned MAX_REPORTS = 10;

    // Operation mixes of the random bursts.
    localparam int MIX_FILL = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN = 2;

    typedef struct {
        in_item_t    req;
        int unsigned idle;
    } queued_cmd_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  request = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    queued_cmd_t pending_cmds[$];
    out_item_t   expected_results[$];
    entry_t      shadow_entries[$];

    int unsigned idle_count = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_taken = 0;
    int unsigned pushes_dropped = 0;
    int unsigned empty_reads = 0;
    int unsigned keyed_hits = 0;
    int unsigned keyed_misses = 0;
    int unsigned peak_fill = 0;

    fifo_with_keyed_removal dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Applies one accepted item to the shadow queue and returns the result it must give.
    function automatic out_item_t apply_to_shadow(input in_item_t req);
        out_item_t res;
        entry_t    head;
        res = '0;
        case (req.operation)
            OP_PUSH:
            begin
                if (shadow_entries.size() >= QUEUE_DEPTH)
                begin
                    res.status = ST_FULL;
                    pushes_dropped++;
                end
                else
                begin
                    shadow_entries.push_back('{req.key_index, req.version, req.value,
                                               req.dest_addr, req.dest_port,
                                               req.sent_seconds, req.sent_microseconds});
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (shadow_entries.size() == 0)
                begin
                    res.status = ST_EMPTY;
                    empty_reads++;
                end
                else
                begin
                    head = shadow_entries[0];
                    res.out_key_index = head.key_index;
                    res.out_version = head.version;
                    res.out_value = head.value;
                    res.out_dest_addr = head.dest_addr;
                    res.out_dest_port = head.dest_port;
                    res.out_sent_seconds = head.sent_seconds;
                    res.out_sent_microseconds = head.sent_microseconds;
                    if (req.operation == OP_POP)
                        void'(shadow_entries.pop_front());
                end
            end
            default:
            begin
                // The oldest entry with this key and a version within the bound goes.
                for (int i = 0; i < shadow_entries.size(); i++)
                begin
                    if (shadow_entries[i].key_index == req.key_index &&
                        shadow_entries[i].version <= req.version)
                    begin
                        shadow_entries.delete(i);
                        res.found = 1'b1;
                        break;
                    end
                end
                if (res.found)
                    keyed_hits++;
                else
                    keyed_misses++;
            end
        endcase
        res.occupancy = 5'(shadow_entries.size());
        if (shadow_entries.size() > peak_fill)
            peak_fill = shadow_entries.size();
        return res;
    endfunction

    function automatic string differing_fields(input out_item_t e, input out_item_t a);
        string s;
        s = "";
        if (e.status !== a.status) s = {s, " status"};
        if (e.found !== a.found) s = {s, " found"};
        if (e.out_key_index !== a.out_key_index) s = {s, " out_key_index"};
        if (e.out_version !== a.out_version) s = {s, " out_version"};
        if (e.out_value !== a.out_value) s = {s, " out_value"};
        if (e.out_dest_addr !== a.out_dest_addr) s = {s, " out_dest_addr"};
        if (e.out_dest_port !== a.out_dest_port) s = {s, " out_dest_port"};
        if (e.out_sent_seconds !== a.out_sent_seconds) s = {s, " out_sent_seconds"};
        if (e.out_sent_microseconds !== a.out_sent_microseconds)
            s = {s, " out_sent_microseconds"};
        if (e.occupancy !== a.occupancy) s = {s, " occupancy"};
        return s;
    endfunction

    function automatic in_item_t make_push(input logic [31:0] key, input logic [31:0] ver,
                                           input logic [31:0] val, input logic [31:0] addr,
                                           input logic [15:0] port, input logic [31:0] secs,
                                           input logic [19:0] usecs);
        in_item_t r;
        r = '{OP_PUSH, key, ver, val, addr, port, secs, usecs};
        return r;
    endfunction

    function automatic in_item_t make_cmd(input logic [1:0] op, input logic [31:0] key,
                                          input logic [31:0] ver);
        in_item_t r;
        r = '{op, key, ver, $urandom, $urandom, 16'($urandom), $urandom, 20'($urandom)};
        return r;
    endfunction

    // Keys mostly come from a small pool so that removals find matches.
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0: k = $urandom;
            1: k = 32'hFFFF_FFFF;
            default: k = $urandom_range(0, 7);
        endcase
        return k;
    endfunction

    function automatic in_item_t random_cmd(input int mix);
        in_item_t    r;
        int unsigned roll;
        logic [1:0]  op;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  op = roll < 65 ? OP_PUSH : roll < 75 ? OP_POP : roll < 85 ? OP_PEEK
                                                                             : OP_REMOVE;
            MIX_DRAIN: op = roll < 15 ? OP_PUSH : roll < 55 ? OP_POP : roll < 70 ? OP_PEEK
                                                                             : OP_REMOVE;
            default:   op = roll < 35 ? OP_PUSH : roll < 60 ? OP_POP : roll < 75 ? OP_PEEK
                                                                             : OP_REMOVE;
        endcase
        r = make_cmd(op, pick_key(), 32'd0);
        case ($urandom_range(0, 5))
            0: r.version = $urandom;
            1: r.version = (op == OP_REMOVE) ? 32'hFFFF_FFFF : 32'd0;
            default: r.version = $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 4) != 0)
            r.sent_microseconds = 20'($urandom_range(0, 999999));
        return r;
    endfunction

    task automatic queue_cmd(input in_item_t r, input int unsigned idle);
        pending_cmds.push_back('{r, idle});
    endtask

    // Driver: offers queued items, keeping start high while busy holds one off.
    always @(posedge clk or negedge rst_n)
    begin
        queued_cmd_t cmd;
        if (!rst_n)
        begin
            start <= 1'b0;
            idle_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(apply_to_shadow(request));
                items_taken++;
            end
            if (start && busy)
                ;
            else if (pending_cmds.size() == 0)
                start <= 1'b0;
            else if (idle_count < pending_cmds[0].idle)
            begin
                start <= 1'b0;
                idle_count <= idle_count + 1;
            end
            else
            begin
                cmd = pending_cmds.pop_front();
                request <= cmd.req;
                start <= 1'b1;
                idle_count <= 0;
            end
        end
    end

    // Monitor: every result strobe is checked against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        string     diffs;
        if (rst_n && done !== 1'b0)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: %p", results_seen,
                             result);
            end
            else
            begin
                want = expected_results.pop_front();
                diffs = differing_fields(want, result);
                if (done !== 1'b1)
                    diffs = {diffs, " done"};
                if (diffs != "")
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result %0d differs in%s", results_seen, diffs);
                        $display("  expected %p", want);
                        $display("  actual   %p", result);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("fifo_with_keyed_removal: mismatch");
            $finish;
        end
    end

    initial
    begin
        int unsigned made;
        int          mix;
        int unsigned burst;
        bit          calm;

        // Directed: empty reads, extreme payloads, fill to full, keyed removals.
        queue_cmd(make_cmd(OP_POP, 32'd0, 32'd0), 0);
        queue_cmd(make_cmd(OP_PEEK, 32'd0, 32'd0), 1);
        queue_cmd(make_cmd(OP_REMOVE, 32'd0, 32'hFFFF_FFFF), 0);
        queue_cmd(make_push('1, '1, '1, '1, '1, '1, '1), 0);
        queue_cmd(make_push('0, '0, '0, '0, '0, '0, '0), 0);
        queue_cmd(make_cmd(OP_PEEK, 32'd0, 32'd0), 0);
        queue_cmd(make_cmd(OP_POP, 32'd0, 32'd0), 2);
        for (int i = 1; i < QUEUE_DEPTH; i++)
            queue_cmd(make_push(i % 8, 100 - i,
                                i == 1 ? 32'h8000_0000 : i == 2 ? 32'h7FFF_FFFF : $urandom,
                                $urandom, 16'($urandom), $urandom,
                                i == 3 ? 20'd999999 : 20'($urandom_range(0, 999999))), 0);
        // The queue is full now, so this push is dropped.
        queue_cmd(make_push(32'd9, 32'd9, $urandom, $urandom, 16'd80, $urandom, 20'd0), 0);
        // Key 3 holds version 97 ahead of 89: the bound skips the older one.
        queue_cmd(make_cmd(OP_REMOVE, 32'd3, 32'd90), 0);
        queue_cmd(make_cmd(OP_REMOVE, 32'd2, 32'd50), 1);
        queue_cmd(make_cmd(OP_REMOVE, 32'd0, 32'd0), 0);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            mix = $urandom_range(MIX_FILL, MIX_EVEN);
            burst = $urandom_range(8, 40);
            calm = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < burst; j++)
            begin
                queue_cmd(random_cmd(mix), calm ? 0 : $urandom_range(0, 3));
                made++;
            end
        end

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d items taken and %0d results checked; peak occupancy %0d", items_taken,
                 results_seen, peak_fill);
        $display("%0d pushes dropped when full, %0d empty reads, %0d keyed hits, %0d misses",
                 pushes_dropped, empty_reads, keyed_hits, keyed_misses);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("fifo_with_keyed_removal: match");
        else
            $display("fifo_with_keyed_removal: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
